FILE: rtl/core/bb3s_pkg.sv
// Shared constants, register codes and stage types for the 3x3 box blur stream unit.
package bb3s_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int PIX_W        = 8;
    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int WIN_TAPS     = 6;
    localparam int MIN_DIM      = 3;
    localparam int SUM_W        = 12;
    localparam int RECIP_W      = 13;
    localparam int RECIP        = 7282;
    localparam int RECIP_SHIFT  = 16;
    localparam int ROUND_BIAS   = 4;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } reg_idx_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             border;
        logic             interior;
    } tag_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [PIX_W-1:0] px;
        tag_t             tag;
    } stage_t;

endpackage

FILE: rtl/core/bb3s_ifs.sv
// Valid/ready channel interfaces for pixels, results and register writes.
interface bb3s_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bb3s_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bb3s_res_if;
    logic                        valid;
    logic                        ready;
    logic [bb3s_pkg::ROW_W-1:0]  out_row;
    logic [bb3s_pkg::COL_W-1:0]  out_col;
    logic [bb3s_pkg::PIX_W-1:0]  out_value;
    logic                        last_of_run;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last_of_run, output ready);
endinterface

interface bb3s_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bb3s_pkg::CFG_IDX_W-1:0]    index;
    logic [bb3s_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/box_blur_3x3_stream_unit.sv
// Top level of the streaming 3x3 box blur: registers, raster counters and pipeline.
//
// Usage:
//   pix carries 8-bit grayscale pixels in raster order; res carries results with
//   their row and column; cfg writes frame_width (index 0) or frame_height
//   (index 1). A write to either register restarts the frame and is taken at once (ready
//   stays high); write only while the pipeline is empty.
//   Border pixels come out unchanged; interior pixels come out as the rounded
//   mean of their 3x3 neighborhood, one row and one column behind the pixel
//   that completes them. Each pixel causes zero, one or two results, and
//   last_of_run marks the final one.
// Timing:
//   An accepted pixel passes stage A (line store read), stage B (neighborhood
//   sum) and the output register (mean multiply). One pixel per cycle is sustained
//   while res is ready; a pixel with two results (last column from row 2 on, last
//   row from column 2 on) issues them in turn and stalls the pipeline behind it.
// Reset: geometry returns to 640x480, counters and pipeline clear; line
//   stores keep their contents. When res stalls, the pipeline holds; pix ready
//   drops when both stages and the output register fill, B holding a result.
module box_blur_3x3_stream_unit (
    input  logic         clk,
    input  logic         rst_n,
    bb3s_pix_if.sink     pix,
    bb3s_res_if.source   res,
    bb3s_cfg_if.sink     cfg
);

    logic [bb3s_pkg::WIDTH_CFG_W-1:0]  width_reg;
    logic [bb3s_pkg::HEIGHT_CFG_W-1:0] height_reg;
    logic [bb3s_pkg::COL_W-1:0]        col_reg;
    logic [bb3s_pkg::ROW_W-1:0]        row_reg;
    logic [bb3s_pkg::WIDTH_CFG_W-1:0]  w_eff;
    logic [bb3s_pkg::HEIGHT_CFG_W-1:0] h_eff;
    logic [bb3s_pkg::WIDTH_CFG_W-1:0]  col_plus;
    logic [bb3s_pkg::HEIGHT_CFG_W-1:0] row_plus;
    logic                              is_narrow;
    logic                              cfg_write;
    logic                              pix_accept;
    logic                              pix_ready;
    bb3s_pkg::tag_t                    tag;
    logic                              s_valid;
    logic                              s_ready;
    bb3s_pkg::stage_t                  s_data;

    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid;
    assign pix.ready  = pix_ready;
    assign pix_accept = pix.valid && pix_ready;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = bb3s_pkg::WIDTH_CFG_W'(1);
        end
        else if (width_reg > bb3s_pkg::WIDTH_CFG_W'(bb3s_pkg::MAX_WIDTH))
        begin
            w_eff = bb3s_pkg::WIDTH_CFG_W'(bb3s_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = bb3s_pkg::HEIGHT_CFG_W'(1);
        end
        else if (height_reg > bb3s_pkg::HEIGHT_CFG_W'(bb3s_pkg::MAX_HEIGHT))
        begin
            h_eff = bb3s_pkg::HEIGHT_CFG_W'(bb3s_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign col_plus  = bb3s_pkg::WIDTH_CFG_W'(col_reg) + bb3s_pkg::WIDTH_CFG_W'(1);
    assign row_plus  = bb3s_pkg::HEIGHT_CFG_W'(row_reg) + bb3s_pkg::HEIGHT_CFG_W'(1);
    assign is_narrow = (w_eff < bb3s_pkg::WIDTH_CFG_W'(bb3s_pkg::MIN_DIM))
                    || (h_eff < bb3s_pkg::HEIGHT_CFG_W'(bb3s_pkg::MIN_DIM));

    assign tag.row      = row_reg;
    assign tag.col      = col_reg;
    assign tag.border   = is_narrow || (row_reg == '0) || (col_reg == '0)
                       || (row_plus == h_eff) || (col_plus == w_eff);
    assign tag.interior = !is_narrow
                       && (row_reg >= bb3s_pkg::ROW_W'(bb3s_pkg::MIN_DIM - 1))
                       && (col_reg >= bb3s_pkg::COL_W'(bb3s_pkg::MIN_DIM - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bb3s_pkg::WIDTH_RESET;
            height_reg <= bb3s_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                bb3s_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg <= cfg.data[bb3s_pkg::WIDTH_CFG_W-1:0];
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                bb3s_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg.data[bb3s_pkg::HEIGHT_CFG_W-1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
        else if (pix_accept)
        begin
            if (col_plus >= w_eff)
            begin
                col_reg <= '0;
                if (row_plus >= h_eff)
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_plus[bb3s_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                col_reg <= col_plus[bb3s_pkg::COL_W-1:0];
            end
        end
    end

    bb3s_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix_ready),
        .in_px    (pix.pixel_in),
        .in_tag   (tag),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data)
    );

    bb3s_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .res     (res)
    );

`ifndef ASSERT_OFF
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bb3s_pkg::WIDTH_CFG_W'(col_reg) < w_eff)
        else $error("column counter outside frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bb3s_pkg::HEIGHT_CFG_W'(row_reg) < h_eff)
        else $error("row counter outside frame height");
`endif

endmodule

FILE: rtl/core/bb3s_ram.sv
// Generic simple dual-port RAM with registered read.
module bb3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bb3s_window.sv
// Line stores, 3x3 window and neighborhood sum stage.
module bb3s_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bb3s_pkg::PIX_W-1:0]  in_px,
    input  bb3s_pkg::tag_t              in_tag,
    output logic                        s_valid,
    input  logic                        s_ready,
    output bb3s_pkg::stage_t            s_data
);

    logic                        valid_a_reg;
    logic [bb3s_pkg::PIX_W-1:0]  px_a_reg;
    bb3s_pkg::tag_t              tag_a_reg;
    logic [bb3s_pkg::PIX_W-1:0]  win_reg [bb3s_pkg::WIN_TAPS];
    logic [bb3s_pkg::PIX_W-1:0]  top;
    logic [bb3s_pkg::PIX_W-1:0]  mid;
    logic [bb3s_pkg::SUM_W-1:0]  sum;
    logic                        load;
    logic                        advance;

    assign advance  = valid_a_reg && s_ready;
    assign in_ready = !valid_a_reg || s_ready;
    assign load     = in_valid && in_ready;

    bb3s_ram #(
        .WIDTH (bb3s_pkg::PIX_W),
        .DEPTH (bb3s_pkg::MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (advance),
        .waddr (tag_a_reg.col),
        .wdata (mid),
        .re    (load),
        .raddr (in_tag.col),
        .rdata (top)
    );

    bb3s_ram #(
        .WIDTH (bb3s_pkg::PIX_W),
        .DEPTH (bb3s_pkg::MAX_WIDTH)
    ) u_middle (
        .clk   (clk),
        .we    (advance),
        .waddr (tag_a_reg.col),
        .wdata (px_a_reg),
        .re    (load),
        .raddr (in_tag.col),
        .rdata (mid)
    );

    always_comb
    begin
        sum = bb3s_pkg::SUM_W'(px_a_reg) + bb3s_pkg::SUM_W'(top) + bb3s_pkg::SUM_W'(mid);
        for (int i = 0; i < bb3s_pkg::WIN_TAPS; i++)
        begin
            sum = sum + bb3s_pkg::SUM_W'(win_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_a_reg  <= in_px;
            tag_a_reg <= in_tag;
        end
        if (advance)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= px_a_reg;
        end
    end

    assign s_valid    = valid_a_reg;
    assign s_data.sum = sum;
    assign s_data.px  = px_a_reg;
    assign s_data.tag = tag_a_reg;

`ifndef ASSERT_OFF
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a_reg && !s_ready |=> valid_a_reg && $stable(px_a_reg) && $stable(tag_a_reg))
        else $error("stage A item changed while stalled");
`endif

endmodule

FILE: rtl/core/bb3s_out.sv
// Mean stage, result sequencing and output register.
module bb3s_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bb3s_pkg::stage_t     s_data,
    bb3s_res_if.source           res
);

    localparam int PROD_W = bb3s_pkg::SUM_W + bb3s_pkg::RECIP_W;

    logic                        b_valid_reg;
    logic                        phase_reg;
    bb3s_pkg::stage_t            b_reg;
    logic                        out_valid_reg;
    logic [bb3s_pkg::ROW_W-1:0]  out_row_reg;
    logic [bb3s_pkg::COL_W-1:0]  out_col_reg;
    logic [bb3s_pkg::PIX_W-1:0]  out_value_reg;
    logic                        out_last_reg;
    logic [bb3s_pkg::SUM_W-1:0]  biased;
    logic [PROD_W-1:0]           prod;
    logic [bb3s_pkg::PIX_W-1:0]  mean;
    logic                        emit_border;
    logic                        has_result;
    logic                        cur_last;
    logic                        out_free;
    logic                        b_fire;
    logic                        b_done;

    assign biased = b_reg.sum + bb3s_pkg::SUM_W'(bb3s_pkg::ROUND_BIAS);
    assign prod   = PROD_W'(biased) * PROD_W'(bb3s_pkg::RECIP);
    assign mean   = prod[bb3s_pkg::RECIP_SHIFT +: bb3s_pkg::PIX_W];

    assign emit_border = b_reg.tag.border && !phase_reg;
    assign has_result  = emit_border || b_reg.tag.interior;
    assign cur_last    = !(emit_border && b_reg.tag.interior);
    assign out_free    = !out_valid_reg || res.ready;
    assign b_fire      = b_valid_reg && has_result && out_free;
    assign b_done      = b_valid_reg && (!has_result || (out_free && cur_last));
    assign s_ready     = !b_valid_reg || b_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_ready)
            begin
                b_valid_reg <= s_valid;
                phase_reg   <= 1'b0;
            end
            else if (b_fire)
            begin
                phase_reg <= 1'b1;
            end
            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            b_reg <= s_data;
        end
        if (b_fire)
        begin
            out_last_reg <= cur_last;
            if (emit_border)
            begin
                out_row_reg   <= b_reg.tag.row;
                out_col_reg   <= b_reg.tag.col;
                out_value_reg <= b_reg.px;
            end
            else
            begin
                out_row_reg   <= b_reg.tag.row - bb3s_pkg::ROW_W'(1);
                out_col_reg   <= b_reg.tag.col - bb3s_pkg::COL_W'(1);
                out_value_reg <= mean;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_row     = out_row_reg;
    assign res.out_col     = out_col_reg;
    assign res.out_value   = out_value_reg;
    assign res.last_of_run = out_last_reg;

`ifndef ASSERT_OFF
    a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> b_valid_reg && b_reg.tag.border && b_reg.tag.interior)
        else $error("second result pending for an item with one result");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire && !cur_last |=> b_valid_reg && phase_reg)
        else $error("item left before its second result");
`endif

endmodule

FILE: test/box_blur_3x3_stream_unit_test.sv
// Testbench for box_blur_3x3_stream_unit: directed and random frames checked against a 3x3 mean predictor.
`timescale 1ns / 1ps

module box_blur_3x3_stream_unit_test;
    import bb3s_pkg::*;

    localparam int          TOTAL_PIXELS  = 1850;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
    } blur_result_t;

    class blur_checker;
        logic [WIDTH_CFG_W-1:0]  width_reg;
        logic [HEIGHT_CFG_W-1:0] height_reg;
        logic [PIX_W-1:0]        upper_row [MAX_WIDTH];
        logic [PIX_W-1:0]        middle_row [MAX_WIDTH];
        logic [PIX_W-1:0]        window [WIN_TAPS];
        int unsigned             col;
        int unsigned             row;
        blur_result_t            due_results [$];
        int unsigned             errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_row[i]) upper_row[i] = '0;
            foreach (middle_row[i]) middle_row[i] = '0;
            foreach (window[i]) window[i] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function int unsigned dim_limit(int unsigned value, int unsigned top);
            if (value < 1) return 1;
            if (value > top) return top;
            return value;
        endfunction

        function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = value[WIDTH_CFG_W-1:0];
            end
            else if (idx == REG_FRAME_HEIGHT) begin
                height_reg = value[HEIGHT_CFG_W-1:0];
            end
            else begin
                return;
            end
            col = 0;
            row = 0;
        endfunction

        function void push_expect(int unsigned r, int unsigned c, int unsigned v, bit last);
            blur_result_t item;
            item.row   = r[ROW_W-1:0];
            item.col   = c[COL_W-1:0];
            item.value = v[PIX_W-1:0];
            item.last  = last;
            due_results.push_back(item);
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned top;
            int unsigned mid;
            int unsigned sum;
            bit          narrow;
            bit          on_edge;
            bit          interior;
            w   = dim_limit(width_reg, MAX_WIDTH);
            h   = dim_limit(height_reg, MAX_HEIGHT);
            top = upper_row[col];
            mid = middle_row[col];
            upper_row[col]  = mid[PIX_W-1:0];
            middle_row[col] = px;
            sum = top + mid + px;
            foreach (window[i]) sum += window[i];
            narrow   = (w < MIN_DIM) || (h < MIN_DIM);
            on_edge  = narrow || row == 0 || col == 0 || row + 1 == h || col + 1 == w;
            interior = !narrow && row >= 2 && col >= 2;
            if (on_edge) push_expect(row, col, px, !interior);
            if (interior) push_expect(row - 1, col - 1, (sum + ROUND_BIAS) / 9, 1'b1);
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top[PIX_W-1:0];
            window[4] = mid[PIX_W-1:0];
            window[5] = px;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                   logic [PIX_W-1:0] v, logic last);
            blur_result_t want;
            if (due_results.size() == 0) begin
                $error("unexpected result: row %0d col %0d value %0d", r, c, v);
                errors++;
                return;
            end
            want = due_results.pop_front();
            check_field("out_row", want.row, r);
            check_field("out_col", want.col, c);
            check_field("out_value", want.value, v);
            check_field("last_of_run", want.last, last);
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    bit          hold_request = 1'b0;
    blur_checker sb = new();

    bb3s_pix_if pix_ch ();
    bb3s_res_if res_ch ();
    bb3s_cfg_if cfg_ch ();

    box_blur_3x3_stream_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("box_blur_3x3_stream_unit_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned rx_cycles;
        int unsigned hold_left;
        bit          hold_taken;
        rx_cycles  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            rx_cycles++;
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.out_row, res_ch.out_col, res_ch.out_value,
                                res_ch.last_of_run);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (rx_cycles >= 3000 && rx_cycles < 5000) begin
                res_ch.ready <= 1'b1;
            end
            else begin
                res_ch.ready <= ($urandom_range(99) >= 36);
            end
        end
    end

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.apply_reg_write(idx, value);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_data,
                                input logic [CFG_DATA_W-1:0] h_data);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w_data);
        write_reg(REG_FRAME_HEIGHT, h_data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic poke_spare_reg();
        wait_drained();
        write_reg($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2,
                  CFG_DATA_W'($urandom_range(8191)));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (!(sent >= 300 && sent < 700)) begin
            while ($urandom_range(99) < 36) begin
                pix_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= px;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        sb.note_pixel(px);
        sent++;
    endtask

    initial
    begin
        int unsigned             sel;
        int unsigned             w;
        int unsigned             h;
        int unsigned             frame_px;
        int unsigned             n;
        int                      spare_at;
        logic [CFG_DATA_W-1:0]   w_data;
        logic [CFG_DATA_W-1:0]   h_data;
        logic [PIX_W-1:0]        px;

        pix_ch.valid    <= 1'b0;
        pix_ch.pixel_in <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_FRAME_WIDTH;
        cfg_ch.data     <= '0;
        rst_n           <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_geometry(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) poke_spare_reg();
            send_pixel(8'hFF);
        end
        set_geometry(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd5 : 8'd0);
        set_geometry(13'd0, 13'd0);
        send_pixel(8'd128);
        send_pixel(8'd1);
        set_geometry(13'h1FFF, 13'h1FFF);
        send_pixel(8'h00);
        send_pixel(8'hAA);
        send_pixel(8'h55);

        while (sent < TOTAL_PIXELS) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 2);
                if ($urandom_range(1)) begin
                    frame_px = w;
                    w        = h;
                    h        = frame_px;
                end
                w_data = CFG_DATA_W'(w);
                h_data = CFG_DATA_W'(h);
            end
            else if (sel < 18) begin
                w_data = $urandom_range(1) ? 13'd0 : CFG_DATA_W'($urandom_range(2049, 4095));
                h_data = $urandom_range(1) ? 13'd0 : CFG_DATA_W'($urandom_range(4097, 8191));
            end
            else begin
                w_data = CFG_DATA_W'($urandom_range(3, 24));
                h_data = CFG_DATA_W'($urandom_range(3, 12));
            end
            w_data[CFG_DATA_W-1] = $urandom_range(1);
            w = sb.dim_limit(w_data[WIDTH_CFG_W-1:0], MAX_WIDTH);
            h = sb.dim_limit(h_data, MAX_HEIGHT);
            frame_px = w * h;
            if ((sel >= 12 && sel < 18) || $urandom_range(99) < 20)
                n = $urandom_range(1, frame_px < 300 ? frame_px : 300);
            else
                n = frame_px * $urandom_range(1, 2);
            if (n > 400) n = 400;
            spare_at = ($urandom_range(99) < 30) ? int'($urandom_range(n - 1)) : -1;

            set_geometry(w_data, h_data);
            if (sent >= 700) hold_request = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (i == spare_at || sent == 1200) poke_spare_reg();
                if ($urandom_range(99) < 15)
                    px = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    px = PIX_W'($urandom_range(255));
                send_pixel(px);
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("box_blur_3x3_stream_unit_test OK");
        else
            $display("box_blur_3x3_stream_unit_test NOT OK");
        $finish;
    end

endmodule
